// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the IMU bias calibration RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define IBCC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define IBCC_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define IBCC_ASSERT(lbl, clk, rst, prop, msg)
`define IBCC_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

// ----- rtl/ibcc_pkg.sv -----
// Types and constants for the IMU bias calibration and correction block.
`default_nettype none
package ibcc_pkg;

   localparam int AXES       = 6;
   localparam int AXIS_W     = 16;
   localparam int SUM_W      = 32;
   localparam int AXIS_IDX_W = 3;
   localparam int CNT_W      = 16;
   localparam int DATA_W     = AXES * AXIS_W;

   // Axis positions inside a word
   localparam logic [AXIS_IDX_W-1:0] AXIS_AZ   = 3'd2;
   localparam logic [AXIS_IDX_W-1:0] AXIS_LAST = 3'd5;

   // One g in raw accelerometer units
   localparam logic [SUM_W-1:0] ONE_G = 32'd16384;

   localparam logic [CNT_W-1:0] SAMPLE_COUNT_RESET = 16'd64;

   // Result status codes
   localparam logic [1:0] STAT_ACCUM = 2'd0;
   localparam logic [1:0] STAT_DONE  = 2'd1;
   localparam logic [1:0] STAT_FAIL  = 2'd2;
   localparam logic [1:0] STAT_CORR  = 2'd3;

   // Shared adder operations
   localparam logic ALU_ADD = 1'b0;
   localparam logic ALU_SUB = 1'b1;

   // Divider status towards the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage
`default_nettype wire

// ----- rtl/ibcc_alu.sv -----
// Shared 32-bit add/subtract unit used by the correct, accumulate and offset write-back steps.
`default_nettype none
module ibcc_alu (
   input  wire logic                     op,
   input  wire logic [ibcc_pkg::SUM_W-1:0] a,
   input  wire logic [ibcc_pkg::SUM_W-1:0] b,
   output logic      [ibcc_pkg::SUM_W-1:0] y
);
   import ibcc_pkg::*;

   // Add or subtract with wrap
   always_comb begin
      unique case (op)
         ALU_SUB: y = a - b;
         default: y = a + b;
      endcase
   end

endmodule
`default_nettype wire

// ----- rtl/ibcc_div.sv -----
// Radix-2 restoring divider: signed 32-bit sum by unsigned 16-bit count, truncated.
`default_nettype none
module ibcc_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [ibcc_pkg::SUM_W-1:0]   dividend,
   input  wire logic [ibcc_pkg::CNT_W-1:0]   divisor,
   output ibcc_pkg::div_stat_type            stat,
   output logic      [ibcc_pkg::AXIS_W-1:0]  quotient
);
   import ibcc_pkg::*;

   localparam int STEP_W = 5;
   localparam logic [STEP_W-1:0] STEPS = 5'd16;

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              neg_ff,  neg_in;
   logic [CNT_W-1:0]  rem_ff,  rem_in;
   logic [AXIS_W-1:0] quo_ff,  quo_in;
   logic [CNT_W-1:0]  dvs_ff,  dvs_in;
   logic [SUM_W-1:0]  mag;
   logic [CNT_W:0]    trial;
   logic              fits;

   // Magnitude of the dividend; the quotient is known to fit in 16 bits
   assign mag   = dividend[SUM_W-1] ? (SUM_W'(0) - dividend) : dividend;
   assign trial = {rem_ff, quo_ff[AXIS_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   // One quotient bit per cycle
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      neg_in  = neg_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEPS;
         neg_in  = dividend[SUM_W-1];
         rem_in  = mag[SUM_W-1:AXIS_W];
         quo_in  = mag[AXIS_W-1:0];
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (step_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_ff - 1'b1;
            rem_in  = fits ? CNT_W'(trial - {1'b0, dvs_ff}) : trial[CNT_W-1:0];
            quo_in  = {quo_ff[AXIS_W-2:0], fits};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   // Restore the sign on the way out
   assign quotient  = neg_ff ? (AXIS_W'(0) - quo_ff) : quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = busy_ff && (step_ff == '0);

endmodule
`default_nettype wire

// ----- rtl/imu_bias_calibrate_correct.sv -----
// Top level: sequencer, axis registers and result register of the IMU bias block.
// A closing word of a run does six divides, one per axis, on the one shared divider.
// Throughput: one word at a time; the next word is taken once the result is loaded
// into the output register, so a waiting result does not block the next accept.
// Reset (synchronous, high): sums, frame count and offsets cleared, count set to 64.
`default_nettype none
`include "assert_macros.svh"
module imu_bias_calibrate_correct (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z (16 bits each, from bit 0)
   input  wire logic [ibcc_pkg::DATA_W-1:0]   req_tdata,
   // req_type (bit 0), frame_valid (bit 1)
   input  wire logic [1:0]                    req_tuser,
   // response channel
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // out_accel_x .. out_gyro_z (16 bits each, from bit 0)
   output logic      [ibcc_pkg::DATA_W-1:0]   rsp_tdata,
   // status (bits 1:0)
   output logic      [1:0]                    rsp_tuser,
   // sample count register
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [ibcc_pkg::CNT_W-1:0]    csr_data
);
   import ibcc_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CORR   = 3'd1;
   localparam logic [2:0] ST_ACC    = 3'd2;
   localparam logic [2:0] ST_CHK    = 3'd3;
   localparam logic [2:0] ST_DSTART = 3'd4;
   localparam logic [2:0] ST_DWAIT  = 3'd5;
   localparam logic [2:0] ST_DWB    = 3'd6;
   localparam logic [2:0] ST_OUT    = 3'd7;

   logic [2:0]            state_ff,  state_in;
   logic [AXIS_IDX_W-1:0] axis_ff,   axis_in;
   logic [CNT_W-1:0]      frames_ff, frames_in;
   logic [CNT_W-1:0]      count_ff,  count_in;
   logic [1:0]            status_ff, status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]     rsp_data_ff,  rsp_data_in;
   logic [1:0]            rsp_user_ff,  rsp_user_in;

   logic [AXIS_W-1:0] samp_ff [AXES];
   logic [SUM_W-1:0]  sums_ff [AXES];
   logic [AXIS_W-1:0] offs_ff [AXES];
   logic [AXIS_W-1:0] res_ff  [AXES];

   logic              req_acc;
   logic              samp_we, run_clr, sum_we, offs_we, res_we, res_clr, rsp_load;
   logic              div_start;
   div_stat_type      div_stat;
   logic [AXIS_W-1:0] div_q;
   logic              alu_op;
   logic [SUM_W-1:0]  alu_a, alu_b, alu_y;
   logic [AXIS_W-1:0] samp_sel, offs_sel;

   assign req_acc    = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign samp_sel   = samp_ff[axis_ff];
   assign offs_sel   = offs_ff[axis_ff];

   ibcc_alu u_alu (
      .op (alu_op),
      .a  (alu_a),
      .b  (alu_b),
      .y  (alu_y)
   );

   ibcc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sums_ff[axis_ff]),
      .divisor  (frames_ff),
      .stat     (div_stat),
      .quotient (div_q)
   );

   // Sequencer: walk the six axes through the shared adder and divider
   always_comb begin
      state_in  = state_ff;
      axis_in   = axis_ff;
      frames_in = frames_ff;
      status_in = status_ff;
      samp_we   = 1'b0;
      run_clr   = 1'b0;
      sum_we    = 1'b0;
      offs_we   = 1'b0;
      res_we    = 1'b0;
      res_clr   = 1'b0;
      rsp_load  = 1'b0;
      div_start = 1'b0;
      alu_op    = ALU_ADD;
      alu_a     = '0;
      alu_b     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               samp_we = 1'b1;
               res_clr = 1'b1;
               axis_in = '0;
               if (req_tuser[0]) begin
                  state_in = ST_CORR;
               end else if (count_ff == '0 || !req_tuser[1]) begin
                  run_clr   = 1'b1;
                  status_in = STAT_FAIL;
                  state_in  = ST_OUT;
               end else begin
                  state_in = ST_ACC;
               end
            end
         end
         ST_CORR: begin
            alu_op = ALU_SUB;
            alu_a  = {{(SUM_W-AXIS_W){samp_sel[AXIS_W-1]}}, samp_sel};
            alu_b  = {{(SUM_W-AXIS_W){offs_sel[AXIS_W-1]}}, offs_sel};
            res_we = 1'b1;
            if (axis_ff == AXIS_LAST) begin
               status_in = STAT_CORR;
               state_in  = ST_OUT;
            end else begin
               axis_in = axis_ff + 1'b1;
            end
         end
         ST_ACC: begin
            alu_op = ALU_ADD;
            alu_a  = sums_ff[axis_ff];
            alu_b  = {{(SUM_W-AXIS_W){samp_sel[AXIS_W-1]}}, samp_sel};
            sum_we = 1'b1;
            if (axis_ff == AXIS_LAST) begin
               frames_in = frames_ff + 1'b1;
               axis_in   = '0;
               state_in  = ST_CHK;
            end else begin
               axis_in = axis_ff + 1'b1;
            end
         end
         ST_CHK: begin
            if (frames_ff != '0 && frames_ff >= count_ff) begin
               state_in = ST_DSTART;
            end else begin
               status_in = STAT_ACCUM;
               state_in  = ST_OUT;
            end
         end
         ST_DSTART: begin
            div_start = 1'b1;
            state_in  = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (div_stat.done) begin
               state_in = ST_DWB;
            end
         end
         ST_DWB: begin
            // Take one g off the Z-accel offset
            alu_op  = ALU_SUB;
            alu_a   = {{(SUM_W-AXIS_W){1'b0}}, div_q};
            alu_b   = (axis_ff == AXIS_AZ) ? ONE_G : '0;
            offs_we = 1'b1;
            res_we  = 1'b1;
            if (axis_ff == AXIS_LAST) begin
               run_clr   = 1'b1;
               status_in = STAT_DONE;
               state_in  = ST_OUT;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = ST_DSTART;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (run_clr) begin
         frames_in = '0;
      end
   end

   // Hold the result word until the far side takes it
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         rsp_data_in[i*AXIS_W +: AXIS_W] = res_ff[i];
      end
      rsp_user_in  = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (!rsp_load) begin
         rsp_data_in = rsp_data_ff;
         rsp_user_in = rsp_user_ff;
      end else begin
         rsp_valid_in = 1'b1;
      end
   end

   assign count_in = (csr_valid && csr_ready) ? csr_data : count_ff;

   // Control and calibration state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= '0;
         frames_ff    <= '0;
         count_ff     <= SAMPLE_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < AXES; i++) begin
            sums_ff[i] <= '0;
            offs_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         frames_ff    <= frames_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (run_clr) begin
            for (int i = 0; i < AXES; i++) begin
               sums_ff[i] <= '0;
            end
         end else if (sum_we) begin
            sums_ff[axis_ff] <= alu_y;
         end
         if (offs_we) begin
            offs_ff[axis_ff] <= alu_y[AXIS_W-1:0];
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      if (samp_we) begin
         for (int i = 0; i < AXES; i++) begin
            samp_ff[i] <= req_tdata[i*AXIS_W +: AXIS_W];
         end
      end
      if (res_clr) begin
         for (int i = 0; i < AXES; i++) begin
            res_ff[i] <= '0;
         end
      end else if (res_we) begin
         res_ff[axis_ff] <= alu_y[AXIS_W-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `IBCC_ASSERT(a_zero_payload, clock, reset, (rsp_tvalid && (rsp_tuser == STAT_ACCUM || rsp_tuser == STAT_FAIL) |-> rsp_tdata == '0), "accumulate or fail word carries non-zero axes")
   `IBCC_ASSERT(a_wait_busy, clock, reset, (state_ff == ST_DWAIT |-> div_stat.busy), "waiting on an idle divider")
   `IBCC_ASSERT(a_run_cleared, clock, reset, ((state_ff == ST_DWB && axis_ff == AXIS_LAST) |=> frames_ff == '0), "frame count not cleared after a finished run")

endmodule
`default_nettype wire
